// File: src/osa_pkg.sv
`default_nettype none
package osa_pkg;

  localparam int MaxClientsDef = 16;
  localparam int NumSlotsDef   = 4;
  localparam int IdBitsDef     = 16;

  typedef enum logic [2:0] {
    MODE_REGISTER = 3'd0,
    MODE_REQUEST  = 3'd1,
    MODE_RELEASE  = 3'd2,
    MODE_REMOVE   = 3'd3,
    MODE_SET_FULL = 3'd4,
    MODE_CLR_FULL = 3'd5,
    MODE_QUERY    = 3'd6,
    MODE_UNUSED   = 3'd7
  } mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] client_id;
  } in_beat_t;

  typedef struct packed {
    logic       is_known;
    logic       has_slot;
    logic [1:0] slot_index;
    logic       in_bed;
    logic [2:0] free_count;
    logic       table_full;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_SHIFT,
    ST_PASS1,
    ST_PASS2,
    ST_REPORT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_idx;
    logic step_search;
    logic apply;
    logic step_shift;
    logic step_pass1;
    logic step_pass2;
    logic report;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic found;
    logic is_remove;
    logic shift_last;
  } ctl_sts_t;

endpackage
`default_nettype wire

// File: src/osa_ctrl.sv
`default_nettype none
module osa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_busy,
  input  wire osa_pkg::ctl_sts_t sts,
  output osa_pkg::ctl_cmd_t      cmd,
  output logic                   idle
);
  import osa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_SEARCH;
      ST_SEARCH: if (sts.found || sts.idx_last) state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = sts.is_remove ? ST_SHIFT : ST_PASS1;
      ST_SHIFT:  if (sts.shift_last) state_nxt = ST_PASS1;
      ST_PASS1:  if (sts.idx_last) state_nxt = ST_PASS2;
      ST_PASS2:  if (sts.idx_last) state_nxt = ST_REPORT;
      ST_REPORT: if (sts.found || sts.idx_last) state_nxt = ST_DONE;
      ST_DONE:   if (!out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
        cmd.clr_idx = 1'b1;
      end
      ST_SEARCH: begin
        cmd.step_search = 1'b1;
        cmd.clr_idx = sts.found || sts.idx_last;
      end
      ST_APPLY:  cmd.apply = 1'b1;
      ST_SHIFT: begin
        cmd.step_shift = 1'b1;
        cmd.clr_idx = sts.shift_last;
      end
      ST_PASS1: begin
        cmd.step_pass1 = 1'b1;
        cmd.clr_idx = sts.idx_last;
      end
      ST_PASS2: begin
        cmd.step_pass2 = 1'b1;
        cmd.clr_idx = sts.idx_last;
      end
      ST_REPORT: cmd.step_search = 1'b1;
      ST_DONE:   cmd.report = !out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/osa_dp.sv
`default_nettype none
module osa_dp #(
  parameter int MAX_CLIENTS = osa_pkg::MaxClientsDef,
  parameter int NUM_SLOTS   = osa_pkg::NumSlotsDef,
  parameter int ID_BITS     = osa_pkg::IdBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire osa_pkg::in_beat_t  in_data,
  input  wire osa_pkg::ctl_cmd_t  cmd,
  output osa_pkg::ctl_sts_t       sts,
  output osa_pkg::out_beat_t      res
);
  import osa_pkg::*;

  localparam int IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW = $clog2(MAX_CLIENTS + 1);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FW = $clog2(NUM_SLOTS + 1);

  logic [ID_BITS-1:0] ent_id_r    [MAX_CLIENTS];
  logic               ent_wants_r [MAX_CLIENTS];
  logic               ent_full_r  [MAX_CLIENTS];
  logic               ent_holds_r [MAX_CLIENTS];
  logic [SW-1:0]      ent_slot_r  [MAX_CLIENTS];

  logic [CW-1:0]        count_r;
  logic [NUM_SLOTS-1:0] busy_r;
  logic                 fh_valid_r;
  logic [ID_BITS-1:0]   fh_id_r;
  logic [2:0]           mode_r;
  logic [ID_BITS-1:0]   id_r;
  logic [IW-1:0]        idx_r;
  logic [IW-1:0]        hit_r;
  logic                 found_r;
  logic                 refused_r;

  logic           in_range, hit_now, q_now, any_free, has_next;
  logic [SW-1:0]  low_free;
  logic [FW-1:0]  free_n;
  logic [IW-1:0]  nxt;
  logic [CW-1:0]  idx_ext, hit_ext;

  assign idx_ext  = CW'(idx_r);
  assign hit_ext  = CW'(hit_r);
  assign in_range = idx_ext < count_r;
  assign hit_now  = in_range && (ent_id_r[idx_r] == id_r);
  assign q_now    = ent_wants_r[idx_r] && !ent_full_r[idx_r];
  assign nxt      = IW'(idx_ext + CW'(1));
  assign has_next = (hit_ext + CW'(1)) < count_r;

  always_comb begin
    low_free = '0;
    any_free = 1'b0;
    free_n   = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (!busy_r[s]) begin
        low_free = SW'(s);
        any_free = 1'b1;
        free_n   = free_n + FW'(1);
      end
    end
  end

  always_comb begin
    sts.found      = hit_now;
    sts.idx_last   = (idx_ext + CW'(1)) >= count_r;
    sts.is_remove  = (mode_r == MODE_REMOVE) && found_r;
    sts.shift_last = !has_next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      busy_r     <= '0;
      fh_valid_r <= 1'b0;
      fh_id_r    <= '0;
      found_r    <= 1'b0;
      refused_r  <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.step_search || cmd.step_pass1 || cmd.step_pass2) begin
        idx_r <= nxt;
      end
      if (cmd.load) begin
        mode_r    <= in_data.mode;
        id_r      <= ID_BITS'(in_data.client_id);
        found_r   <= 1'b0;
        refused_r <= 1'b0;
      end
      if (cmd.step_search) begin
        found_r <= hit_now;
        hit_r   <= idx_r;
      end
      if (cmd.apply) begin
        case (mode_r)
          MODE_REGISTER, MODE_REQUEST: begin
            if (found_r) begin
              if (mode_r == MODE_REQUEST) ent_wants_r[hit_r] <= 1'b1;
            end else if (count_r >= CW'(MAX_CLIENTS)) begin
              refused_r <= 1'b1;
            end else begin
              ent_id_r[IW'(count_r)]    <= id_r;
              ent_wants_r[IW'(count_r)] <= (mode_r == MODE_REQUEST);
              ent_holds_r[IW'(count_r)] <= 1'b0;
              ent_slot_r[IW'(count_r)]  <= '0;
              ent_full_r[IW'(count_r)]  <= fh_valid_r && (fh_id_r == id_r);
              count_r <= count_r + CW'(1);
            end
          end
          MODE_RELEASE: if (found_r) ent_wants_r[hit_r] <= 1'b0;
          MODE_REMOVE: begin
            if (found_r && ent_holds_r[hit_r]) busy_r[ent_slot_r[hit_r]] <= 1'b0;
          end
          MODE_SET_FULL: begin
            fh_valid_r <= 1'b1;
            fh_id_r    <= id_r;
            for (int i = 0; i < MAX_CLIENTS; i++) ent_full_r[i] <= (ent_id_r[i] == id_r);
          end
          MODE_CLR_FULL: begin
            fh_valid_r <= 1'b0;
            fh_id_r    <= '0;
            for (int i = 0; i < MAX_CLIENTS; i++) ent_full_r[i] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.step_shift) begin
        if (has_next) begin
          ent_id_r[hit_r]    <= ent_id_r[IW'(hit_ext + CW'(1))];
          ent_wants_r[hit_r] <= ent_wants_r[IW'(hit_ext + CW'(1))];
          ent_full_r[hit_r]  <= ent_full_r[IW'(hit_ext + CW'(1))];
          ent_holds_r[hit_r] <= ent_holds_r[IW'(hit_ext + CW'(1))];
          ent_slot_r[hit_r]  <= ent_slot_r[IW'(hit_ext + CW'(1))];
          hit_r <= IW'(hit_ext + CW'(1));
        end else begin
          count_r <= count_r - CW'(1);
        end
      end
      if (cmd.step_pass1 && in_range && !q_now && ent_holds_r[idx_r]) begin
        busy_r[ent_slot_r[idx_r]] <= 1'b0;
        ent_holds_r[idx_r] <= 1'b0;
        ent_slot_r[idx_r]  <= '0;
      end
      if (cmd.step_pass2 && in_range && q_now && !ent_holds_r[idx_r] && any_free) begin
        busy_r[low_free]   <= 1'b1;
        ent_holds_r[idx_r] <= 1'b1;
        ent_slot_r[idx_r]  <= low_free;
      end
      if (cmd.report) begin
        res.is_known   <= found_r;
        res.has_slot   <= found_r && ent_holds_r[hit_r];
        res.slot_index <= (found_r && ent_holds_r[hit_r]) ? 2'(ent_slot_r[hit_r]) : 2'd0;
        res.in_bed     <= found_r && !ent_holds_r[hit_r];
        res.free_count <= 3'(free_n);
        res.table_full <= refused_r;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/ordered_slot_allocator.sv
// Channel | Direction | Payload
// in_     | input     | in_beat_t (mode, client_id)
// out_    | output    | out_beat_t (slot status, free count, table_full)
// An event runs from its input beat to its result through the sequential lookup, compaction
// on a remove, two reconcile sweeps and final lookup, then the block returns to idle before
// the next input beat is taken.
// Reset is synchronous on rst_n and empties the table and frees all slots.
// A result beat waits in the output register; the next input beat is taken meanwhile, and
// that event stalls at its end until the held beat leaves.
`default_nettype none
module ordered_slot_allocator #(
  parameter int MAX_CLIENTS = osa_pkg::MaxClientsDef,
  parameter int NUM_SLOTS   = osa_pkg::NumSlotsDef,
  parameter int ID_BITS     = osa_pkg::IdBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire osa_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output osa_pkg::out_beat_t      out_data
);
  import osa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     idle, in_fire, out_valid_r;

  assign in_ready  = idle;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  osa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (out_valid_r && !out_ready),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  osa_dp #(
    .MAX_CLIENTS (MAX_CLIENTS),
    .NUM_SLOTS   (NUM_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .res     (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.report) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_report_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |-> !(out_valid_r && !out_ready)) else $error("report over held beat");
  a_out_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> out_valid && !(out_data.has_slot && out_data.in_bed))
    else $error("slot and bed both set");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("accept while busy");

endmodule
`default_nettype wire
